@@ hw/rtl/dts_pkg.sv @@
// dts_pkg: shared types and constants of the dfs topological sort block
// depends on nothing; used by dfs_topological_sort and dts_checker
`default_nettype none

package dts_pkg;

  // fixed field widths
  localparam int unsigned VTX_W      = 6;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [0:0] {
    OP_EDGE = 1'b0,
    OP_SORT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    COLOR_WHITE = 2'd0,
    COLOR_GRAY  = 2'd1,
    COLOR_BLACK = 2'd2
  } color_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_ROOT,
    ST_ROOT_CHK,
    ST_SCAN,
    ST_COLOR_CHK,
    ST_POP_RD,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_CYCLE_OUT
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/dfs_topological_sort.sv @@
// dfs_topological_sort: adjacency matrix loader and depth-first topological sorter
// depends on dts_pkg
`default_nettype none

// Edge words (tuser = 0) set one bit of an adjacency matrix held in a row memory;
// an edge naming a vertex at or above the vertex count is dropped. A sort word
// (tuser = 1) runs a depth-first search with an explicit stack memory, roots and
// neighbors in ascending order, then streams every vertex in reverse finishing
// order with tlast on the final word, or one word with acyclic = 0 and vertex 0
// when a gray neighbor (self-loop included) shows a cycle. After the run the
// matrix and colors are cleared through per-row valid bits, so no clearing pass
// is needed. An edge word is a row read, then a read-modify-write. A sort word
// holds tready low while the search runs, with the shared scan step testing
// one matrix column per cycle; emission then reads each vertex through the
// order memory's registered read port. The output register lets the next
// edge words enter while the last result waits to be taken.

module dfs_topological_sort #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration: vertex_count
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dts_pkg::CFG_W-1:0]       cfg_data_i,
  // input words
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [5:0] source_vertex, [11:6] target_vertex, [15:12] zero
  input  wire logic [dts_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [0] opcode
  input  wire logic [0:0]                      s_axis_tuser_i,
  // result words
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [5:0] ordered_vertex, [7:6] zero
  output logic [dts_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // [0] acyclic
  output logic [0:0]                           m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;  // vertex index
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);                       // counts 0..max

  typedef struct packed {
    logic [CW-1:0] resume;
    logic [AW-1:0] vtx;
  } stk_entry_t;

  // control registers
  dts_pkg::state_e state_q, state_d;
  logic [dts_pkg::CFG_W-1:0] cfg_q;
  logic [CW-1:0] n_q, n_d;            // vertex count latched for the run
  logic [CW-1:0] root_q, root_d;      // root scan position
  logic [CW-1:0] depth_q, depth_d;    // stack depth, top kept in cur_*
  logic [CW-1:0] fill_q, fill_d;      // next order slot, counts down
  logic [CW-1:0] emit_q, emit_d;      // emission index
  logic [AW-1:0] cur_v_q, cur_v_d;    // vertex on top of the stack
  logic [CW-1:0] cur_j_q, cur_j_d;    // next neighbor column to test
  logic [MAX_VERTICES-1:0] adj_vld_q, adj_vld_d;
  logic [MAX_VERTICES-1:0] color_vld_q, color_vld_d;
  logic out_vld_q, out_vld_d;

  // payload registers
  logic [AW-1:0] src_q, dst_q;
  logic          edge_ok_q;
  logic [dts_pkg::VTX_W-1:0] out_vtx_q, out_vtx_d;
  logic out_acyc_q, out_acyc_d, out_last_q, out_last_d;

  // memories and their ports
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd_q, adj_wdata;
  logic adj_re, adj_we;
  logic [AW-1:0] adj_raddr;

  dts_pkg::color_e color_mem [MAX_VERTICES];
  dts_pkg::color_e color_rd_q, color_wdata;
  logic color_re, color_we;
  logic [AW-1:0] color_raddr, color_waddr;

  stk_entry_t stk_mem [MAX_VERTICES];
  stk_entry_t stk_rd_q, stk_wdata;
  logic stk_re, stk_we;
  logic [AW-1:0] stk_raddr, stk_waddr;

  logic [AW-1:0] topo_mem [MAX_VERTICES];
  logic [AW-1:0] topo_rd_q;
  logic topo_re, topo_we;
  logic [AW-1:0] topo_raddr, topo_waddr;

  // input field views
  logic [dts_pkg::VTX_W-1:0] in_src, in_dst;
  logic in_acc, in_sort, out_free;
  logic [CW-1:0] n_eff;
  logic edge_in_range;
  logic scan_done, scan_hit, root_done, pop_last, emit_last;
  logic [MAX_VERTICES-1:0] dst_onehot;

  assign in_src  = s_axis_tdata_i[dts_pkg::VTX_W-1:0];
  assign in_dst  = s_axis_tdata_i[2*dts_pkg::VTX_W-1:dts_pkg::VTX_W];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_sort = (s_axis_tuser_i[0] == dts_pkg::OP_SORT);

  // out-of-range counts clamp to 1..MAX_VERTICES
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CW'(1);
    end else if (cfg_q > dts_pkg::CFG_W'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(cfg_q);
    end
  end

  assign edge_in_range = ({1'b0, in_src} < dts_pkg::CFG_W'(n_eff)) &&
                         ({1'b0, in_dst} < dts_pkg::CFG_W'(n_eff));

  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign scan_done  = (cur_j_q == n_q);
  assign scan_hit   = adj_rd_q[cur_j_q[AW-1:0]];
  assign root_done  = (root_q == n_q);
  assign pop_last   = (depth_q == CW'(1));
  assign emit_last  = ((emit_q + CW'(1)) == n_q);
  assign dst_onehot = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << dst_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = in_sort ? dts_pkg::ST_ROOT : dts_pkg::ST_EDGE_WR;
        end
      end
      dts_pkg::ST_EDGE_WR: state_d = dts_pkg::ST_IDLE;
      dts_pkg::ST_ROOT: begin
        state_d = root_done ? dts_pkg::ST_EMIT_RD : dts_pkg::ST_ROOT_CHK;
      end
      dts_pkg::ST_ROOT_CHK: begin
        state_d = (color_rd_q == dts_pkg::COLOR_WHITE) ? dts_pkg::ST_SCAN : dts_pkg::ST_ROOT;
      end
      dts_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = pop_last ? dts_pkg::ST_ROOT : dts_pkg::ST_POP_RD;
        end else if (scan_hit) begin
          state_d = dts_pkg::ST_COLOR_CHK;
        end
      end
      dts_pkg::ST_COLOR_CHK: begin
        state_d = (color_rd_q == dts_pkg::COLOR_GRAY) ? dts_pkg::ST_CYCLE_OUT
                                                      : dts_pkg::ST_SCAN;
      end
      dts_pkg::ST_POP_RD:  state_d = dts_pkg::ST_SCAN;
      dts_pkg::ST_EMIT_RD: state_d = dts_pkg::ST_EMIT_WAIT;
      dts_pkg::ST_EMIT_WAIT: begin
        if (out_free) begin
          state_d = emit_last ? dts_pkg::ST_IDLE : dts_pkg::ST_EMIT_RD;
        end
      end
      dts_pkg::ST_CYCLE_OUT: begin
        if (out_free) begin
          state_d = dts_pkg::ST_IDLE;
        end
      end
      default: state_d = dts_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    n_d         = n_q;
    root_d      = root_q;
    depth_d     = depth_q;
    fill_d      = fill_q;
    emit_d      = emit_q;
    cur_v_d     = cur_v_q;
    cur_j_d     = cur_j_q;
    adj_vld_d   = adj_vld_q;
    color_vld_d = color_vld_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_vtx_d   = out_vtx_q;
    out_acyc_d  = out_acyc_q;
    out_last_d  = out_last_q;

    adj_re      = 1'b0;
    adj_raddr   = cur_v_q;
    adj_we      = 1'b0;
    adj_wdata   = adj_rd_q | dst_onehot;
    color_re    = 1'b0;
    color_raddr = root_q[AW-1:0];
    color_we    = 1'b0;
    color_waddr = cur_v_q;
    color_wdata = dts_pkg::COLOR_GRAY;
    stk_re      = 1'b0;
    stk_raddr   = AW'(depth_q - CW'(2));
    stk_we      = 1'b0;
    stk_waddr   = AW'(depth_q - CW'(1));
    stk_wdata   = '{resume: cur_j_q + CW'(1), vtx: cur_v_q};
    topo_re     = 1'b0;
    topo_raddr  = emit_q[AW-1:0];
    topo_we     = 1'b0;
    topo_waddr  = AW'(fill_q - CW'(1));

    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        // edge: fetch the source row for the read-modify-write
        adj_raddr = AW'(in_src);
        if (in_acc) begin
          if (in_sort) begin
            n_d    = n_eff;
            fill_d = n_eff;
            root_d = '0;
          end else begin
            adj_re = 1'b1;
          end
        end
      end
      dts_pkg::ST_EDGE_WR: begin
        if (edge_ok_q) begin
          adj_we           = 1'b1;
          adj_vld_d[src_q] = 1'b1;
        end
      end
      dts_pkg::ST_ROOT: begin
        if (root_done) begin
          emit_d = '0;
        end else begin
          color_re = 1'b1;
        end
      end
      dts_pkg::ST_ROOT_CHK: begin
        if (color_rd_q == dts_pkg::COLOR_WHITE) begin
          color_we    = 1'b1;
          color_waddr = root_q[AW-1:0];
          color_vld_d[root_q[AW-1:0]] = 1'b1;
          cur_v_d     = root_q[AW-1:0];
          cur_j_d     = '0;
          depth_d     = CW'(1);
          adj_re      = 1'b1;
          adj_raddr   = root_q[AW-1:0];
        end else begin
          root_d = root_q + CW'(1);
        end
      end
      dts_pkg::ST_SCAN: begin
        if (scan_done) begin
          // vertex finished: blacken, record, pop
          color_we    = 1'b1;
          color_wdata = dts_pkg::COLOR_BLACK;
          topo_we     = 1'b1;
          fill_d      = fill_q - CW'(1);
          depth_d     = depth_q - CW'(1);
          if (pop_last) begin
            root_d = root_q + CW'(1);
          end else begin
            stk_re = 1'b1;
          end
        end else if (scan_hit) begin
          color_re    = 1'b1;
          color_raddr = cur_j_q[AW-1:0];
        end else begin
          cur_j_d = cur_j_q + CW'(1);
        end
      end
      dts_pkg::ST_COLOR_CHK: begin
        case (color_rd_q)
          dts_pkg::COLOR_WHITE: begin
            // push: save the current top, descend into the neighbor
            stk_we      = 1'b1;
            color_we    = 1'b1;
            color_waddr = cur_j_q[AW-1:0];
            color_vld_d[cur_j_q[AW-1:0]] = 1'b1;
            cur_v_d     = cur_j_q[AW-1:0];
            cur_j_d     = '0;
            depth_d     = depth_q + CW'(1);
            adj_re      = 1'b1;
            adj_raddr   = cur_j_q[AW-1:0];
          end
          dts_pkg::COLOR_GRAY: ;
          default: cur_j_d = cur_j_q + CW'(1);
        endcase
      end
      dts_pkg::ST_POP_RD: begin
        cur_v_d   = stk_rd_q.vtx;
        cur_j_d   = stk_rd_q.resume;
        adj_re    = 1'b1;
        adj_raddr = stk_rd_q.vtx;
      end
      dts_pkg::ST_EMIT_RD: begin
        topo_re = 1'b1;
      end
      dts_pkg::ST_EMIT_WAIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_vtx_d  = dts_pkg::VTX_W'(topo_rd_q);
          out_acyc_d = 1'b1;
          out_last_d = emit_last;
          emit_d     = emit_q + CW'(1);
          if (emit_last) begin
            adj_vld_d   = '0;
            color_vld_d = '0;
          end
        end
      end
      dts_pkg::ST_CYCLE_OUT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_vtx_d   = '0;
          out_acyc_d  = 1'b0;
          out_last_d  = 1'b1;
          adj_vld_d   = '0;
          color_vld_d = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dts_pkg::ST_IDLE;
      cfg_q       <= dts_pkg::CFG_RESET;
      n_q         <= CW'(1);
      root_q      <= '0;
      depth_q     <= '0;
      fill_q      <= '0;
      emit_q      <= '0;
      cur_v_q     <= '0;
      cur_j_q     <= '0;
      adj_vld_q   <= '0;
      color_vld_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      n_q         <= n_d;
      root_q      <= root_d;
      depth_q     <= depth_d;
      fill_q      <= fill_d;
      emit_q      <= emit_d;
      cur_v_q     <= cur_v_d;
      cur_j_q     <= cur_j_d;
      adj_vld_q   <= adj_vld_d;
      color_vld_q <= color_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_sort) begin
      src_q     <= AW'(in_src);
      dst_q     <= AW'(in_dst);
      edge_ok_q <= edge_in_range;
    end
    out_vtx_q  <= out_vtx_d;
    out_acyc_q <= out_acyc_d;
    out_last_q <= out_last_d;
  end

  // adjacency rows, an invalid row reads as empty
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[src_q] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd_q <= adj_vld_q[adj_raddr] ? adj_mem[adj_raddr] : '0;
    end
  end

  // vertex colors, an invalid entry reads as white
  always_ff @(posedge clk_i) begin
    if (color_we) begin
      color_mem[color_waddr] <= color_wdata;
    end
    if (color_re) begin
      color_rd_q <= color_vld_q[color_raddr] ? color_mem[color_raddr]
                                             : dts_pkg::COLOR_WHITE;
    end
  end

  // search stack below the cached top
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  // finished order, filled from the back
  always_ff @(posedge clk_i) begin
    if (topo_we) begin
      topo_mem[topo_waddr] <= cur_v_q;
    end
    if (topo_re) begin
      topo_rd_q <= topo_mem[topo_raddr];
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == dts_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = dts_pkg::OUT_DATA_W'(out_vtx_q);
  assign m_axis_tuser_o  = out_acyc_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/dts_checker.sv @@
// dts_checker: port-level checks of dfs_topological_sort, bound to the top level
// depends on dts_pkg and dfs_topological_sort
`default_nettype none

module dts_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o,
  input wire logic [dts_pkg::CFG_W-1:0]       cfg_data_i,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic [dts_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input wire logic [0:0]                      s_axis_tuser_i,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [dts_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input wire logic [0:0]                      m_axis_tuser_o,
  input wire logic                            m_axis_tlast_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // a sort word stalls the input while the search runs
  a_sort_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i[0] == dts_pkg::OP_SORT) |=> !s_axis_tready_o)
    else $error("input ready right after a sort word");

  // an edge word drops input ready for its row update, then ready returns
  a_edge_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i[0] == dts_pkg::OP_EDGE) |=> !s_axis_tready_o ##1 s_axis_tready_o)
    else $error("edge word timing off");

  // a cycle report is a single final word with vertex zero
  a_cycle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("malformed cycle report");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result word changed while stalled");

endmodule

bind dfs_topological_sort dts_checker u_dts_checker (.*);

`default_nettype wire

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench of the dfs topological sort block
// depends on dts_pkg and dfs_topological_sort; loads random graphs, predicts every
// ordered vertex word and compares it on the result stream

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_V         = 64;
  localparam int unsigned ITEM_TARGET   = 460;     // edge and sort words in range
  localparam int unsigned SETTLE_CYCLES = 16;      // lets a trailing edge word finish its row update
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // one word on the input stream
  typedef struct packed {
    dts_pkg::op_e              op;
    logic [dts_pkg::VTX_W-1:0] src;
    logic [dts_pkg::VTX_W-1:0] dst;
  } graph_word_t;

  // one word on the result stream
  typedef struct packed {
    logic [dts_pkg::VTX_W-1:0] vertex;
    logic                      acyclic;
    logic                      last;
  } topo_word_t;

  // dut connections, all inputs known from time zero
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [dts_pkg::CFG_W-1:0]      cfg_data  = '0;
  logic                           s_valid   = 1'b0;
  logic [dts_pkg::IN_DATA_W-1:0]  s_data    = '0;
  logic [0:0]                     s_user    = '0;
  logic                           m_ready   = 1'b0;
  logic                           cfg_ready;
  logic                           s_ready;
  logic                           m_valid;
  logic [dts_pkg::OUT_DATA_W-1:0] m_data;
  logic [0:0]                     m_user;
  logic                           m_last;

  // words waiting for the driver, and ordered vertices still owed by the block
  graph_word_t pending_words [$];
  topo_word_t  due_words [$];

  // the block's state as the predictor sees it
  logic [MAX_V-1:0]          adj_model [MAX_V] = '{default: '0};
  logic [dts_pkg::CFG_W-1:0] count_model       = dts_pkg::CFG_RESET;

  // handshake counters shared between driver, sink and monitor
  int unsigned sent_count   = 0;
  int unsigned accept_count = 0;
  int unsigned result_count = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned taken_seen   = 0;
  int unsigned gap_max      = 7;
  int unsigned stall_max    = 7;

  // run statistics
  int unsigned mismatch_count = 0;
  int unsigned sorts_run      = 0;
  int unsigned cycles_found   = 0;
  int unsigned edges_seen     = 0;
  int unsigned stim_count     = 0;
  int unsigned plan_span      = MAX_V;
  int unsigned cycle_count    = 0;

  dfs_topological_sort #(
    .MAX_VERTICES(MAX_V)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),     // [5:0] source_vertex, [11:6] target_vertex, [15:12] zero
    .s_axis_tuser_i (s_user),     // [0] opcode
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),     // [5:0] ordered_vertex, [7:6] zero
    .m_axis_tuser_o (m_user),     // [0] acyclic
    .m_axis_tlast_o (m_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // a count of 0 behaves as one vertex, anything above the maximum as the maximum
  function automatic int unsigned active_vertices(input logic [dts_pkg::CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_V) return MAX_V;
    return raw;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // depth-first search over the model matrix; queues the words a sort produces
  // and clears the graph afterwards, as the block does
  function automatic void predict_topo_order();
    int unsigned               n, depth, fill, top, v, j;
    bit                        found_cycle;
    dts_pkg::color_e           shade [MAX_V];
    logic [dts_pkg::VTX_W-1:0] path [MAX_V];
    int unsigned               next_col [MAX_V];
    logic [dts_pkg::VTX_W-1:0] finish_order [MAX_V];
    topo_word_t                w;
    n = active_vertices(count_model);
    found_cycle = 1'b0;
    fill = n;
    for (int unsigned i = 0; i < MAX_V; i++) shade[i] = dts_pkg::COLOR_WHITE;
    // roots in ascending order
    for (int unsigned r = 0; r < n && !found_cycle; r++) begin
      if (shade[r] == dts_pkg::COLOR_WHITE) begin
        shade[r] = dts_pkg::COLOR_GRAY;
        path[0] = dts_pkg::VTX_W'(r);
        next_col[0] = 0;
        depth = 1;
        while (depth > 0 && !found_cycle) begin
          top = depth - 1;
          v = path[top];
          j = next_col[top];
          // next neighbor of the top vertex; bits at or above n are stale
          while (j < n && !adj_model[v][j]) j++;
          if (j >= n) begin
            // vertex finished: fill the order from the back
            shade[v] = dts_pkg::COLOR_BLACK;
            if (fill > 0) begin
              fill--;
              finish_order[fill] = dts_pkg::VTX_W'(v);
            end
            depth--;
          end else begin
            next_col[top] = j + 1;
            if (shade[j] == dts_pkg::COLOR_GRAY) begin
              // back edge or self-loop
              found_cycle = 1'b1;
            end else if (shade[j] == dts_pkg::COLOR_WHITE && depth < n) begin
              shade[j] = dts_pkg::COLOR_GRAY;
              path[depth] = dts_pkg::VTX_W'(j);
              next_col[depth] = 0;
              depth++;
            end
          end
        end
      end
    end
    if (found_cycle) begin
      // a cycle gives one word: vertex 0, acyclic low, last high
      w.vertex  = '0;
      w.acyclic = 1'b0;
      w.last    = 1'b1;
      due_words.push_back(w);
      cycles_found++;
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        w.vertex  = finish_order[i];
        w.acyclic = 1'b1;
        w.last    = (i == n - 1);
        due_words.push_back(w);
      end
    end
    for (int unsigned i = 0; i < MAX_V; i++) adj_model[i] = '0;
    sorts_run++;
  endfunction

  // driver: one word in flight, a random gap after each accepted word
  always @(negedge clk) begin : driver
    graph_word_t w;
    logic        next_valid;
    next_valid = s_valid;
    if (accept_count == sent_count) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        s_data <= dts_pkg::IN_DATA_W'({w.dst, w.src});
        s_user <= w.op;
        sent_count++;
        next_valid = 1'b1;
        gap_left = $urandom_range(0, gap_max);
      end
    end
    s_valid <= next_valid;
  end

  // sink: holds ready low for a random stall after each taken word
  always @(negedge clk) begin : sink
    if (taken_seen != result_count) begin
      taken_seen = result_count;
      stall_left = $urandom_range(0, stall_max);
    end
    if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // monitor: tracks the model on every accepted word and checks every result
  always @(posedge clk) begin : monitor
    topo_word_t  got, want;
    int unsigned span;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) count_model = cfg_data;
      if (s_valid && s_ready) begin
        accept_count++;
        if (dts_pkg::op_e'(s_user) == dts_pkg::OP_SORT) begin
          predict_topo_order();
        end else begin
          // edges naming a vertex outside the active range are dropped
          span = active_vertices(count_model);
          edges_seen++;
          if (s_data[5:0] < span && s_data[11:6] < span)
            adj_model[s_data[5:0]][s_data[11:6]] = 1'b1;
        end
      end
      if (m_valid && m_ready) begin
        result_count++;
        got.vertex  = m_data[dts_pkg::VTX_W-1:0];
        got.acyclic = m_user[0];
        got.last    = m_last;
        if (due_words.size() == 0) begin
          report_mismatch($sformatf(
            "result %0d with nothing owed: vertex %0d acyclic %0b last %0b",
            result_count, got.vertex, got.acyclic, got.last));
        end else begin
          want = due_words.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "result %0d: expected vertex %0d acyclic %0b last %0b, got vertex %0d acyclic %0b last %0b",
              result_count, want.vertex, want.acyclic, want.last,
              got.vertex, got.acyclic, got.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("dfs_topological_sort test failed");
      $finish;
    end
  end

  task automatic queue_edge(input int unsigned src, input int unsigned dst);
    graph_word_t w;
    w.op  = dts_pkg::OP_EDGE;
    w.src = dts_pkg::VTX_W'(src);
    w.dst = dts_pkg::VTX_W'(dst);
    pending_words.push_back(w);
    if (src < plan_span && dst < plan_span) stim_count++;
  endtask

  task automatic queue_sort();
    graph_word_t w;
    w.op  = dts_pkg::OP_SORT;
    w.src = dts_pkg::VTX_W'($urandom_range(0, MAX_V - 1));
    w.dst = dts_pkg::VTX_W'($urandom_range(0, MAX_V - 1));
    pending_words.push_back(w);
    stim_count++;
  endtask

  // everything sent, accepted and answered, then a settle wait for a trailing edge word
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || sent_count != accept_count || due_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keep the driver queue short so idle settings track the phase they belong to
  task automatic wait_room();
    while (pending_words.size() > 2) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned raw);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dts_pkg::CFG_W'(raw);
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    plan_span = active_vertices(dts_pkg::CFG_W'(raw));
  endtask

  initial begin : stimulus
    int unsigned raw, span, edge_total, a, b, k, t, cyc_at;
    int unsigned perm [MAX_V];
    bit          add_cycle;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty graph at the reset count, all 64 vertices in reverse
    queue_sort();
    // small graph with a duplicate edge and edges past the count
    write_vertex_count(4);
    queue_edge(0, 1);
    queue_edge(1, 2);
    queue_edge(0, 1);
    queue_edge(0, 3);
    queue_edge(3, 2);
    queue_edge(5, 1);
    queue_edge(63, 63);
    queue_sort();
    // self-loop
    queue_edge(2, 2);
    queue_sort();
    // three-vertex cycle
    queue_edge(0, 1);
    queue_edge(1, 2);
    queue_edge(2, 0);
    queue_sort();
    // count of zero acts as one vertex: self-loop, then a lone vertex
    write_vertex_count(0);
    queue_edge(0, 0);
    queue_sort();
    wait_idle();
    queue_sort();
    // count above the maximum acts as the maximum
    write_vertex_count(127);
    queue_edge(63, 0);
    queue_edge(0, 62);
    queue_sort();
    // cycle loaded at 40 vertices turns stale once the count drops to 10
    write_vertex_count(40);
    queue_edge(5, 30);
    queue_edge(30, 5);
    write_vertex_count(10);
    queue_sort();

    // random graphs: mostly acyclic with random content, some cycles and noise
    while (stim_count < ITEM_TARGET) begin
      wait_room();
      gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 7;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      if ($urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, 9);
        if (k < 6) raw = $urandom_range(1, 12);
        else if (k < 9) raw = $urandom_range(13, 40);
        else begin
          case ($urandom_range(0, 3))
            0:       raw = 0;
            1:       raw = MAX_V;
            default: raw = $urandom_range(MAX_V + 1, 127);
          endcase
        end
        write_vertex_count(raw);
      end
      span = plan_span;

      // random vertex order; forward edges along it keep the graph acyclic
      for (int unsigned i = 0; i < span; i++) perm[i] = i;
      for (int unsigned i = span - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        t = perm[i];
        perm[i] = perm[k];
        perm[k] = t;
      end
      edge_total = $urandom_range(0, (span <= 12) ? 3 * span : ((span < 30) ? 2 * span : 60));
      add_cycle  = ($urandom_range(0, 3) == 0);
      cyc_at     = $urandom_range(0, edge_total);
      for (int unsigned idx = 0; idx <= edge_total; idx++) begin
        if (add_cycle && idx == cyc_at) begin
          // backward edge along the order, a self-loop when both ends match
          a = $urandom_range(0, span - 1);
          b = $urandom_range(a, span - 1);
          queue_edge(perm[b], perm[a]);
        end
        if (idx < edge_total && span > 1) begin
          a = $urandom_range(0, span - 2);
          b = $urandom_range(a + 1, span - 1);
          queue_edge(perm[a], perm[b]);
        end
        if (span < MAX_V && $urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0)
            queue_edge($urandom_range(span, MAX_V - 1), $urandom_range(0, MAX_V - 1));
          else
            queue_edge($urandom_range(0, MAX_V - 1), $urandom_range(span, MAX_V - 1));
        end
      end

      // now and then shrink the count over a loaded graph, or drain before sorting
      if (span > 2 && $urandom_range(0, 7) == 0) write_vertex_count($urandom_range(1, span - 1));
      else if ($urandom_range(0, 5) == 0) wait_idle();
      queue_sort();
    end

    wait_idle();
    $display("ran %0d sorts (%0d with a cycle) over %0d edge words", sorts_run, cycles_found,
             edges_seen);
    $display("checked %0d ordered vertex words, %0d mismatches", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("dfs_topological_sort test passed");
    end else begin
      $display("dfs_topological_sort test failed");
    end
    $finish;
  end

endmodule

@@ dfs_topological_sort.f @@
hw/rtl/dts_pkg.sv
hw/rtl/dfs_topological_sort.sv
hw/rtl/dts_checker.sv
sim/tb_top.sv
